>>> rtl/core/open_address_hash_table_assert.svh
// ----------------------------------------------------------------------------
// open_address_hash_table_assert
// assertion macros used by the hash table controller, clocked on clk_i with reset
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define OAHT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true outside reset
`define OAHT_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/core/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// types and constants of the open address hash table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oaht_pkg;

  // multiplicative hash constants for the two coordinates
  localparam logic [31:0] HASH_MUL_X = 32'h9E3779B9;
  localparam logic [31:0] HASH_MUL_Y = 32'h85EBCA6B;

  // request codes
  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2
  } req_e;

  // slot occupancy codes
  typedef enum logic [1:0] {
    OCC_EMPTY = 2'd0,
    OCC_USED  = 2'd1,
    OCC_TOMB  = 2'd2
  } occ_e;

  // response status codes
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EVAL,
    S_DONE
  } state_e;

  // request transaction payload
  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [15:0]  key_x;
    logic signed [15:0]  key_y;
    logic [15:0]         new_value;
  } req_t;

  // response transaction payload
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_value;
  } rsp_t;

  // one stored slot entry
  typedef struct packed {
    logic [15:0] key_x;
    logic [15:0] key_y;
    logic [15:0] value;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic       clear_en;
    logic       load_req;
    logic       start_probe;
    logic       read_slot;
    logic       advance;
    logic       note_tomb;
    logic       wr_tomb;
    logic       wr_update;
    logic       wr_fill;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_hit;
    logic       out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       occ_empty;
    logic       occ_tomb;
    logic       key_match;
    logic       last_probe;
    logic       have_tomb;
    logic       clear_last;
  } sts_t;

endpackage

>>> rtl/core/open_address_hash_table.sv
// ----------------------------------------------------------------------------
// open_address_hash_table
// linear probing hash table with tombstones, keyed by two signed coordinates
// ----------------------------------------------------------------------------
// After reset the block sweeps the occupancy memory, one slot per cycle,
// with in_ready_o low. Each accepted request then passes through the hash
// multipliers, then, for each probed slot (1 to TABLE_SLOTS of them), one
// step to address the slot memories and one to evaluate their registered
// read data; the result register is loaded at the last evaluation, the
// response register after it once that register is free, and only then is
// a new request taken. One request is in flight at a time.
`timescale 1ns / 1ps

module open_address_hash_table import oaht_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  oaht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and evaluation
  oaht_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

endmodule

>>> rtl/core/oaht_datapath.sv
// ----------------------------------------------------------------------------
// oaht_datapath
// request and hash registers, slot memories, probe address, result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oaht_datapath import oaht_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  in_req_i,
  input  cmd_t  cmd_i,
  output sts_t  sts_o,
  output rsp_t  out_rsp_o
);

  localparam int unsigned IdxW = $clog2(TABLE_SLOTS);

  // slot memories
  logic [1:0] occ_mem [TABLE_SLOTS];
  entry_t     ent_mem [TABLE_SLOTS];

  req_t            req_q;
  logic [IdxW-1:0] prod_x_q, prod_y_q;
  logic [IdxW-1:0] home;
  logic [IdxW-1:0] probe_q, cur_slot_q, count_q, tomb_q, clr_cnt_q;
  logic            first_q, have_tomb_q;
  logic [IdxW-1:0] rd_addr, fill_slot, wr_addr;
  logic [1:0]      occ_rd_q, occ_wd;
  entry_t          ent_rd_q, ent_wd;
  logic            occ_we, ent_we;
  logic [31:0]     sx, sy;
  rsp_t            res_q, out_q;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
    end
  end

  // hash products, low index bits only
  assign sx = {{16{req_q.key_x[15]}}, req_q.key_x};
  assign sy = {{16{req_q.key_y[15]}}, req_q.key_y};

  always_ff @(posedge clk_i) begin
    prod_x_q <= IdxW'(sx * HASH_MUL_X);
    prod_y_q <= IdxW'(sy * HASH_MUL_Y);
  end

  assign home = prod_x_q ^ prod_y_q;

  // probe sequencing
  assign rd_addr = first_q ? home : probe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b0;
      have_tomb_q <= 1'b0;
      count_q     <= '0;
      probe_q     <= '0;
      cur_slot_q  <= '0;
      tomb_q      <= '0;
      clr_cnt_q   <= '0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.start_probe) begin
        first_q     <= 1'b1;
        have_tomb_q <= 1'b0;
        count_q     <= '0;
      end
      if (cmd_i.read_slot) begin
        first_q    <= 1'b0;
        cur_slot_q <= rd_addr;
      end
      if (cmd_i.advance) begin
        probe_q <= cur_slot_q + 1'b1;
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.note_tomb && !have_tomb_q) begin
        have_tomb_q <= 1'b1;
        tomb_q      <= cur_slot_q;
      end
    end
  end

  // write port selection
  assign fill_slot = have_tomb_q ? tomb_q : cur_slot_q;
  assign occ_we    = cmd_i.clear_en | cmd_i.wr_tomb | cmd_i.wr_update | cmd_i.wr_fill;
  assign ent_we    = cmd_i.wr_update | cmd_i.wr_fill;

  always_comb begin
    if (cmd_i.clear_en) begin
      wr_addr = clr_cnt_q;
      occ_wd  = OCC_EMPTY;
    end else if (cmd_i.wr_fill) begin
      wr_addr = fill_slot;
      occ_wd  = OCC_USED;
    end else if (cmd_i.wr_tomb) begin
      wr_addr = cur_slot_q;
      occ_wd  = OCC_TOMB;
    end else begin
      wr_addr = cur_slot_q;
      occ_wd  = OCC_USED;
    end
  end

  assign ent_wd = '{key_x: req_q.key_x, key_y: req_q.key_y, value: req_q.new_value};

  // occupancy memory, registered read
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[wr_addr] <= occ_wd;
    end
    occ_rd_q <= occ_mem[rd_addr];
  end

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[wr_addr] <= ent_wd;
    end
    ent_rd_q <= ent_mem[rd_addr];
  end

  // slot evaluation status
  assign sts_o.op         = req_q.req_type;
  assign sts_o.occ_empty  = (occ_rd_q == OCC_EMPTY);
  assign sts_o.occ_tomb   = (occ_rd_q == OCC_TOMB);
  assign sts_o.key_match  = (occ_rd_q == OCC_USED) &&
                            (ent_rd_q.key_x == $unsigned(req_q.key_x)) &&
                            (ent_rd_q.key_y == $unsigned(req_q.key_y));
  assign sts_o.last_probe = (count_q == '1);
  assign sts_o.have_tomb  = have_tomb_q;
  assign sts_o.clear_last = (clr_cnt_q == '1);

  // result and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q.status      <= cmd_i.res_status;
      res_q.found_value <= cmd_i.res_hit ? ent_rd_q.value : 16'd0;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_rsp_o = out_q;

endmodule

>>> rtl/core/oaht_ctrl.sv
// ----------------------------------------------------------------------------
// oaht_ctrl
// state machine sequencing memory clear, hashing, probing and response
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "open_address_hash_table_assert.svh"

module oaht_ctrl import oaht_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   op_valid, probe_more;

  // keep probing a valid request while the slot neither ends nor answers it and the pass is not complete
  always_comb begin
    case (req_e'(sts_i.op))
      REQ_LOOKUP, REQ_INSERT, REQ_DELETE: op_valid = 1'b1;
      default:                            op_valid = 1'b0;
    endcase
  end

  assign probe_more = op_valid && !sts_i.key_match && !sts_i.occ_empty && !sts_i.last_probe;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (sts_i.clear_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_HASH;
      S_HASH:  state_d = S_READ;
      S_READ:  state_d = S_EVAL;
      S_EVAL:  state_d = probe_more ? S_READ : S_DONE;
      S_DONE:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = STATUS_ABSENT;
    in_ready_o       = 1'b0;
    case (state_q)
      S_CLEAR: cmd_o.clear_en = 1'b1;
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      S_HASH: cmd_o.start_probe = 1'b1;
      S_READ: cmd_o.read_slot = 1'b1;
      S_EVAL: begin
        if (probe_more) begin
          cmd_o.advance   = 1'b1;
          cmd_o.note_tomb = (req_e'(sts_i.op) == REQ_INSERT) && sts_i.occ_tomb;
        end else begin
          cmd_o.res_load = 1'b1;
          case (req_e'(sts_i.op))
            REQ_LOOKUP: begin
              if (sts_i.key_match) begin
                cmd_o.res_status = STATUS_OK;
                cmd_o.res_hit    = 1'b1;
              end
            end
            REQ_DELETE: begin
              if (sts_i.key_match) begin
                cmd_o.res_status = STATUS_OK;
                cmd_o.wr_tomb    = 1'b1;
              end
            end
            REQ_INSERT: begin
              if (sts_i.key_match) begin
                cmd_o.res_status = STATUS_OK;
                cmd_o.wr_update  = 1'b1;
              end else if (sts_i.occ_empty || sts_i.have_tomb || sts_i.occ_tomb) begin
                cmd_o.res_status = STATUS_OK;
                cmd_o.wr_fill    = 1'b1;
              end else begin
                cmd_o.res_status = STATUS_FULL;
              end
            end
            default: cmd_o.res_status = STATUS_ABSENT;
          endcase
        end
      end
      S_DONE: cmd_o.out_load = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  // response valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_o.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `OAHT_ASSERT(a_write_only_at_eval, (cmd_o.wr_tomb || cmd_o.wr_update || cmd_o.wr_fill) |-> (state_q == S_EVAL), "slot write outside evaluation")
  `OAHT_ASSERT(a_single_write, $onehot0({cmd_o.wr_tomb, cmd_o.wr_update, cmd_o.wr_fill}), "more than one slot write at once")
  `OAHT_ASSERT_NEVER(a_advance_past_end, cmd_o.advance && sts_i.last_probe, "probe advanced past a full pass")
  `OAHT_ASSERT(a_out_load_valid, cmd_o.out_load |=> out_valid_q, "response load did not raise valid")
  `OAHT_ASSERT(a_accept_to_hash, (in_valid_i && in_ready_o) |=> (state_q == S_HASH), "accepted request did not start hashing")

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the open address hash table: a directed table of
// requests, a random mix over crowded and scattered key pools, then a fill to
// a full table and probes on it, checked against an in-bench copy of the
// slot table except where a directed response is typed in
`timescale 1ns / 1ps

module testbench;
  import oaht_pkg::*;

  localparam int unsigned SLOTS        = 1024;
  localparam int unsigned RANDOM_ITEMS = 980;
  localparam int unsigned CROWDED_KEYS = 32;
  localparam int unsigned SPREAD_KEYS  = 64;
  localparam int unsigned LONG_HOLD    = 400;
  localparam longint      RUN_LIMIT_NS = 200_000_000;

  // request code the block must ignore
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // one directed request, with its response typed in where pinned is set
  typedef struct packed {
    req_t req;
    logic pinned;
    rsp_t rsp;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;

  // bench copy of the slot table
  occ_e        slot_state [SLOTS];
  entry_t      slot_entry [SLOTS];
  int unsigned live_entries;

  logic [31:0] crowded_keys [CROWDED_KEYS];
  logic [31:0] spread_keys  [SPREAD_KEYS];

  rsp_t        pending_rsps [$];
  int unsigned mismatches = 0;
  int unsigned responses_seen = 0;
  bit          offering;

  always #5 clk_i = ~clk_i;

  open_address_hash_table #(
    .TABLE_SLOTS(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // home slot from the two multiplicative hashes
  function automatic int unsigned home_of(input logic [15:0] kx, input logic [15:0] ky);
    logic [31:0] hx;
    logic [31:0] hy;
    hx = {{16{kx[15]}}, kx} * HASH_MUL_X;
    hy = {{16{ky[15]}}, ky} * HASH_MUL_Y;
    return (hx ^ hy) & (SLOTS - 1);
  endfunction

  function automatic bit key_in_slot(input int unsigned s, input logic [15:0] kx,
                                     input logic [15:0] ky);
    return slot_state[s] == OCC_USED && slot_entry[s].key_x == kx &&
           slot_entry[s].key_y == ky;
  endfunction

  function automatic void fill_slot(input int unsigned s, input req_t req);
    if (slot_state[s] != OCC_USED) live_entries++;
    slot_state[s] = OCC_USED;
    slot_entry[s] = {req.key_x, req.key_y, req.new_value};
  endfunction

  // walk the probe sequence for one request, update the bench table and
  // return the response the block owes
  function automatic rsp_t probe_slots(input req_t req);
    rsp_t        rsp;
    int unsigned s;
    int unsigned n;
    int unsigned tomb;
    bit          have_tomb;
    bit          done;
    rsp        = '0;
    rsp.status = STATUS_ABSENT;
    s          = home_of(req.key_x, req.key_y);
    have_tomb  = 1'b0;
    tomb       = 0;
    done       = 1'b0;
    case (req.req_type)
      REQ_LOOKUP, REQ_DELETE: begin
        // stop at an empty slot, step over tombstones
        for (n = 0; n < SLOTS && !done; n++) begin
          if (slot_state[s] == OCC_EMPTY) begin
            done = 1'b1;
          end else if (key_in_slot(s, req.key_x, req.key_y)) begin
            rsp.status = STATUS_OK;
            if (req.req_type == REQ_LOOKUP) begin
              rsp.found_value = slot_entry[s].value;
            end else begin
              slot_state[s] = OCC_TOMB;
              live_entries--;
            end
            done = 1'b1;
          end else begin
            s = (s + 1) & (SLOTS - 1);
          end
        end
      end
      REQ_INSERT: begin
        // update in place, else first tombstone, else the closing empty slot
        rsp.status = STATUS_FULL;
        for (n = 0; n < SLOTS && !done; n++) begin
          if (key_in_slot(s, req.key_x, req.key_y)) begin
            slot_entry[s].value = req.new_value;
            rsp.status = STATUS_OK;
            done = 1'b1;
          end else begin
            if (slot_state[s] == OCC_TOMB && !have_tomb) begin
              have_tomb = 1'b1;
              tomb = s;
            end
            if (slot_state[s] == OCC_EMPTY) begin
              fill_slot(have_tomb ? tomb : s, req);
              rsp.status = STATUS_OK;
              done = 1'b1;
            end
            s = (s + 1) & (SLOTS - 1);
          end
        end
        if (!done && have_tomb) begin
          fill_slot(tomb, req);
          rsp.status = STATUS_OK;
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  function automatic directed_row_t stim_row(input logic [1:0] op, input logic [15:0] kx,
                                             input logic [15:0] ky, input logic [15:0] value,
                                             input logic pinned, input logic [1:0] status,
                                             input logic [15:0] found);
    return {op, kx, ky, value, pinned, status, found};
  endfunction

  function automatic req_t keyed_request(input logic [1:0] op, input logic [31:0] key);
    req_t req;
    req.req_type         = op;
    {req.key_x, req.key_y} = key;
    req.new_value        = 16'($urandom_range(0, 16'hFFFF));
    return req;
  endfunction

  // mostly pool keys so that hits, collisions and tombstones are common
  function automatic req_t random_request();
    int unsigned roll;
    logic [1:0]  op;
    logic [31:0] key;
    roll = $urandom_range(0, 99);
    if (roll < 35) op = REQ_LOOKUP;
    else if (roll < 70) op = REQ_INSERT;
    else if (roll < 94) op = REQ_DELETE;
    else op = REQ_UNKNOWN;
    roll = $urandom_range(0, 99);
    if (roll < 45) key = crowded_keys[$urandom_range(0, CROWDED_KEYS - 1)];
    else if (roll < 90) key = spread_keys[$urandom_range(0, SPREAD_KEYS - 1)];
    else key = $urandom;
    return keyed_request(op, key);
  endfunction

  // idle cycles: mostly none or short, a few long, none inside a burst
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // present one request until accepted, then log the response it owes
  task automatic offer_request(input req_t req, input bit pinned, input rsp_t pinned_rsp,
                               input int unsigned gap);
    rsp_t predicted;
    if (gap != 0) begin
      if (offering) in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    offering = 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = probe_slots(req);
    pending_rsps.push_back(pinned ? pinned_rsp : predicted);
  endtask

  task automatic offer(input req_t req, input bit burst);
    offer_request(req, 1'b0, '0, pick_gap(burst));
  endtask

  // stop offering until every owed response has come back
  task automatic wait_for_drain();
    if (offering) in_valid_i <= 1'b0;
    offering = 1'b0;
    while (pending_rsps.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // request side
  initial begin : request_side
    directed_row_t directed_rows [$];
    req_t          req;
    logic [31:0]   candidate;
    logic [31:0]   present_key;
    logic [31:0]   fresh_key;
    int unsigned   n;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    offering   = 1'b0;
    foreach (slot_state[i]) slot_state[i] = OCC_EMPTY;
    live_entries = 0;

    // crowded keys all hash into a few slots around the wrap point
    foreach (crowded_keys[i]) begin
      candidate = $urandom;
      while (((home_of(candidate[31:16], candidate[15:0]) + 4) & (SLOTS - 1)) >= 8) begin
        candidate = $urandom;
      end
      crowded_keys[i] = candidate;
    end
    foreach (spread_keys[i]) spread_keys[i] = $urandom;

    // directed table on an empty map
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 16'h0000, 16'h0000,
                                     1'b1, STATUS_ABSENT, 16'h0000));
    directed_rows.push_back(stim_row(REQ_DELETE, 16'h0000, 16'h0000, 16'hFFFF,
                                     1'b1, STATUS_ABSENT, 16'h0000));
    directed_rows.push_back(stim_row(REQ_INSERT, 16'h0000, 16'h0000, 16'h1234,
                                     1'b1, STATUS_OK, 16'h0000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 16'h0000, 16'h0000,
                                     1'b1, STATUS_OK, 16'h1234));
    // most negative x, most positive y
    directed_rows.push_back(stim_row(REQ_INSERT, 16'h8000, 16'h7FFF, 16'hFFFF,
                                     1'b1, STATUS_OK, 16'h0000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h8000, 16'h7FFF, 16'h0000,
                                     1'b1, STATUS_OK, 16'hFFFF));
    directed_rows.push_back(stim_row(REQ_INSERT, 16'h7FFF, 16'h8000, 16'h0000,
                                     1'b1, STATUS_OK, 16'h0000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h7FFF, 16'h8000, 16'hFFFF,
                                     1'b1, STATUS_OK, 16'h0000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h7FFF, 16'h7FFF, 16'h0000,
                                     1'b1, STATUS_ABSENT, 16'h0000));
    // update in place
    directed_rows.push_back(stim_row(REQ_INSERT, 16'h0000, 16'h0000, 16'hA5A5,
                                     1'b1, STATUS_OK, 16'h0000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 16'h0000, 16'h0000,
                                     1'b1, STATUS_OK, 16'hA5A5));
    // unknown request leaves the map alone
    directed_rows.push_back(stim_row(REQ_UNKNOWN, 16'h0000, 16'h0000, 16'hFFFF,
                                     1'b1, STATUS_ABSENT, 16'h0000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 16'h0000, 16'h0000,
                                     1'b1, STATUS_OK, 16'hA5A5));
    // delete, then miss on the tombstone, then delete of an absent key
    directed_rows.push_back(stim_row(REQ_DELETE, 16'h0000, 16'h0000, 16'h0000,
                                     1'b1, STATUS_OK, 16'h0000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 16'h0000, 16'h0000,
                                     1'b1, STATUS_ABSENT, 16'h0000));
    directed_rows.push_back(stim_row(REQ_DELETE, 16'h0000, 16'h0000, 16'h0000,
                                     1'b1, STATUS_ABSENT, 16'h0000));
    // reuse after delete, checked by the predictor
    directed_rows.push_back(stim_row(REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'h8000,
                                     1'b0, STATUS_OK, 16'h0000));
    directed_rows.push_back(stim_row(REQ_INSERT, 16'h0000, 16'h0000, 16'h0001,
                                     1'b0, STATUS_OK, 16'h0000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000,
                                     1'b0, STATUS_OK, 16'h0000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 16'h0000, 16'h0000,
                                     1'b0, STATUS_OK, 16'h0000));
    directed_rows.push_back(stim_row(REQ_DELETE, 16'h8000, 16'h7FFF, 16'h0000,
                                     1'b0, STATUS_OK, 16'h0000));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].rsp,
                    pick_gap(1'b0));
    end

    // random mix, with one full drain halfway
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
      offer(random_request(), ((n / 64) % 4) == 3);
    end
    wait_for_drain();

    // fill every slot with fresh keys
    present_key = '0;
    while (live_entries < SLOTS) begin
      present_key = $urandom;
      offer(keyed_request(REQ_INSERT, present_key), 1'b0);
    end

    // full table: whole-table probes, then a tombstone taken after a full pass
    fresh_key = $urandom;
    offer(keyed_request(REQ_INSERT, fresh_key), 1'b0);
    offer(keyed_request(REQ_LOOKUP, fresh_key), 1'b0);
    offer(keyed_request(REQ_DELETE, fresh_key), 1'b0);
    offer(keyed_request(REQ_UNKNOWN, fresh_key), 1'b0);
    offer(keyed_request(REQ_LOOKUP, present_key), 1'b0);
    offer(keyed_request(REQ_INSERT, present_key), 1'b0);
    offer(keyed_request(REQ_LOOKUP, present_key), 1'b0);
    offer(keyed_request(REQ_DELETE, present_key), 1'b0);
    offer(keyed_request(REQ_INSERT, fresh_key), 1'b0);
    offer(keyed_request(REQ_LOOKUP, fresh_key), 1'b0);
    req = keyed_request(REQ_INSERT, $urandom);
    offer(req, 1'b0);

    wait_for_drain();
    repeat (2 * SLOTS + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("open_address_hash_table regression: pass");
    end else begin
      $display("open_address_hash_table regression: fail");
    end
    $finish;
  end

  // response side: random stalls, two long hold-offs, field checks
  initial begin : response_side
    rsp_t        want;
    int unsigned stall;
    bit          taking;
    out_ready_i = 1'b0;
    taking      = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (responses_seen == 300 || responses_seen == 1500) stall = LONG_HOLD;
      else stall = pick_gap(((responses_seen / 64) % 4) == 1);
      if (stall != 0) begin
        if (taking) out_ready_i <= 1'b0;
        taking = 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      if (!taking) out_ready_i <= 1'b1;
      taking = 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      responses_seen++;
      if (pending_rsps.size() == 0) begin
        $error("response with no request outstanding: status %0d found_value %h",
               out_rsp_o.status, out_rsp_o.found_value);
        mismatches++;
      end else begin
        want = pending_rsps.pop_front();
        if (out_rsp_o.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_rsp_o.status);
          mismatches++;
        end
        if (out_rsp_o.found_value !== want.found_value) begin
          $error("found_value mismatch: expected %h, got %h", want.found_value,
                 out_rsp_o.found_value);
          mismatches++;
        end
      end
    end
  end

  // hard stop if the block hangs
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("open_address_hash_table regression: fail");
    $finish;
  end

endmodule
